@@ rtl/dipole_rotational_diffusion_step_macros.svh @@
// Assertion macros for the dipole rotational diffusion step block.
`ifndef DIPOLE_ROTATIONAL_DIFFUSION_STEP_MACROS_SVH
`define DIPOLE_ROTATIONAL_DIFFUSION_STEP_MACROS_SVH
`ifndef SYNTH
`define DRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drs assertion failed");
`define DRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drs assertion failed");
`else
`define DRS_ASSERT_IMP(lbl, ante, cons)
`define DRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/drs_pkg.sv @@
// Shared widths, register codes and types of the dipole rotational diffusion step.
package drs_pkg;
  localparam int DIP_W      = 32;
  localparam int MAG_W      = DIP_W - 1;
  localparam int FRAC_W     = 24;
  localparam int UNIT_W     = 30;
  localparam int GAIN_W     = 24;
  localparam int NOISE_W    = 16;
  localparam int NOISE_FRAC = 12;
  localparam int WP_W       = GAIN_W + NOISE_W + 1;
  localparam int W_W        = WP_W - NOISE_FRAC;
  localparam int XP_W       = W_W + DIP_W;
  localparam int P_W        = XP_W - FRAC_W;
  localparam int G_W        = P_W + 2;
  localparam int LEN_W      = 6;
  localparam int GS_W       = UNIT_W + 2;
  localparam int SQ_W       = 2 * UNIT_W + 2;
  localparam int N_W        = UNIT_W + 1;
  localparam int Q_W        = UNIT_W + 1;
  localparam int DV_W       = 2 * UNIT_W + 1;
  localparam int REM_W      = N_W + 3;
  localparam int UP_W       = 2 * GS_W;
  localparam int RS_W       = UP_W - UNIT_W;
  localparam int ADDR_W     = 3;
  localparam int IDX_W      = ADDR_W - 2;
  localparam int APB_W      = 32;

  localparam logic [IDX_W-1:0] REG_GAIN   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PLANAR = IDX_W'(1);

  typedef struct packed {
    logic              planar;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [2:0][DIP_W-1:0] mu;
    logic [MAG_W-1:0]      mag;
    logic                  active;
    logic                  degen;
  } side_t;
endpackage

@@ rtl/drs_in_if.sv @@
// Input channel: one particle word per handshake.
interface drs_in_if import drs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DIP_W-1:0]   dip_x;
  logic signed [DIP_W-1:0]   dip_y;
  logic signed [DIP_W-1:0]   dip_z;
  logic [MAG_W-1:0]          dip_magnitude;
  logic                      in_group;
  logic signed [NOISE_W-1:0] noise_x;
  logic signed [NOISE_W-1:0] noise_y;
  logic signed [NOISE_W-1:0] noise_z;

  modport source (output valid, dip_x, dip_y, dip_z, dip_magnitude, in_group,
                  noise_x, noise_y, noise_z, input ready);
  modport sink (input valid, dip_x, dip_y, dip_z, dip_magnitude, in_group,
                noise_x, noise_y, noise_z, output ready);
endinterface

@@ rtl/drs_out_if.sv @@
// Output channel: one updated dipole word per handshake.
interface drs_out_if import drs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIP_W-1:0] new_x;
  logic signed [DIP_W-1:0] new_y;
  logic signed [DIP_W-1:0] new_z;
  logic                    degenerate;

  modport source (output valid, new_x, new_y, new_z, degenerate, input ready);
  modport sink (input valid, new_x, new_y, new_z, degenerate, output ready);
endinterface

@@ rtl/drs_rotate.sv @@
// Angular step, cross product and rotated vector: three register stages.
module drs_rotate import drs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  cfg_t                    cfg_i,
  input  logic                    valid_i,
  input  side_t                   side_i,
  input  logic [2:0][NOISE_W-1:0] noise_i,
  output logic                    valid_o,
  output side_t                   side_o,
  output logic [2:0][G_W-1:0]     g_o
);
  logic [2:0]            vld_q;
  side_t                 side1_q, side2_q, side3_q;
  logic [2:0][W_W-1:0]   w_d, w_q;
  logic [2:0][P_W-1:0]   pa_d, pa_q, pb_d, pb_q;
  logic [2:0][G_W-1:0]   g_d, g_q;

  always_comb begin
    logic signed [WP_W-1:0] wp;
    for (int k = 0; k < 3; k++) begin
      wp = $signed({1'b0, cfg_i.gain}) * $signed(noise_i[k]);
      wp = wp + (WP_W'(1) << (NOISE_FRAC - 1));
      w_d[k] = wp[NOISE_FRAC +: W_W];
      if (cfg_i.planar && k != 2) begin
        w_d[k] = '0;
      end
    end
  end

  always_comb begin
    logic signed [XP_W-1:0] xa, xb;
    for (int k = 0; k < 3; k++) begin
      xa = $signed(w_q[(k + 1) % 3]) * $signed(side1_q.mu[(k + 2) % 3]);
      xb = $signed(w_q[(k + 2) % 3]) * $signed(side1_q.mu[(k + 1) % 3]);
      xa = xa + (XP_W'(1) << (FRAC_W - 1));
      xb = xb + (XP_W'(1) << (FRAC_W - 1));
      pa_d[k] = xa[FRAC_W +: P_W];
      pb_d[k] = xb[FRAC_W +: P_W];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_d[k] = G_W'($signed(side2_q.mu[k])) + G_W'($signed(pa_q[k]))
             - G_W'($signed(pb_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q     <= w_d;
      side1_q <= side_i;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      side2_q <= side1_q;
      g_q     <= g_d;
      side3_q <= side2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign side_o  = side3_q;
  assign g_o     = g_q;
endmodule

@@ rtl/drs_norm.sv @@
// Normalizing shift and sum of squares: five register stages.
module drs_norm import drs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [2:0][G_W-1:0]  g_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic [2:0][GS_W-1:0] gs_o,
  output logic [SQ_W-1:0]      sum_o
);
  logic [4:0]            vld_q;
  side_t                 side_d;
  side_t                 s4_q, s5_q, s6_q, s7_q, s8_q;
  logic [G_W-1:0]        or_d, or_q;
  logic [2:0][G_W-1:0]   g4_q, g5_q;
  logic [LEN_W-1:0]      len_d, len_q;
  logic [2:0][GS_W-1:0]  gs_d, gs6_q, gs7_q, gs8_q;
  logic [2:0][SQ_W-1:0]  sq_d, sq_q;
  logic [SQ_W-1:0]       sum_d, sum_q;

  always_comb begin
    logic [G_W-1:0] a;
    or_d = '0;
    for (int k = 0; k < 3; k++) begin
      a = g_i[k][G_W-1] ? (~g_i[k] + G_W'(1)) : g_i[k];
      or_d = or_d | a;
    end
    side_d = side_i;
    side_d.degen = side_i.active && (or_d == '0);
  end

  always_comb begin
    len_d = '0;
    for (int b = 0; b < G_W; b++) begin
      if (or_q[b]) begin
        len_d = LEN_W'(b + 1);
      end
    end
  end

  always_comb begin
    logic signed [G_W-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      if (len_q > LEN_W'(UNIT_W)) begin
        sh = $signed(g5_q[k]) >>> (len_q - LEN_W'(UNIT_W));
      end else begin
        sh = $signed(g5_q[k]) <<< (LEN_W'(UNIT_W) - len_q);
      end
      gs_d[k] = sh[GS_W-1:0];
    end
  end

  always_comb begin
    logic signed [UP_W-1:0] p;
    for (int k = 0; k < 3; k++) begin
      p = $signed(gs6_q[k]) * $signed(gs6_q[k]);
      sq_d[k] = p[SQ_W-1:0];
    end
    sum_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q  <= side_d;
      or_q  <= or_d;
      g4_q  <= g_i;
      s5_q  <= s4_q;
      len_q <= len_d;
      g5_q  <= g4_q;
      s6_q  <= s5_q;
      gs6_q <= gs_d;
      s7_q  <= s6_q;
      gs7_q <= gs6_q;
      sq_q  <= sq_d;
      s8_q  <= s7_q;
      gs8_q <= gs7_q;
      sum_q <= sum_d;
    end
  end

  assign valid_o = vld_q[4];
  assign side_o  = s8_q;
  assign gs_o    = gs8_q;
  assign sum_o   = sum_q;
endmodule

@@ rtl/drs_sqrt.sv @@
// Pipelined integer square root: one root bit per register stage.
module drs_sqrt import drs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [2:0][GS_W-1:0] gs_i,
  input  logic [SQ_W-1:0]      sum_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic [2:0][GS_W-1:0] gs_o,
  output logic [N_W-1:0]       root_o
);
  logic                 vld  [N_W+1];
  side_t                sd   [N_W+1];
  logic [2:0][GS_W-1:0] gsa  [N_W+1];
  logic [SQ_W-1:0]      rad  [N_W+1];
  logic [REM_W-1:0]     rem  [N_W+1];
  logic [N_W-1:0]       root [N_W+1];

  assign vld[0]  = valid_i;
  assign sd[0]   = side_i;
  assign gsa[0]  = gs_i;
  assign rad[0]  = sum_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar s = 0; s < N_W; s++) begin : g_bit
    logic [REM_W-1:0] cur, trial;
    logic             take;

    assign cur   = {rem[s][REM_W-3:0], rad[s][SQ_W-1-2*s -: 2]};
    assign trial = REM_W'({root[s], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd[s+1]   <= sd[s];
        gsa[s+1]  <= gsa[s];
        rad[s+1]  <= rad[s];
        rem[s+1]  <= take ? (cur - trial) : cur;
        root[s+1] <= {root[s][N_W-2:0], take};
      end
    end
  end

  assign valid_o = vld[N_W];
  assign side_o  = sd[N_W];
  assign gs_o    = gsa[N_W];
  assign root_o  = root[N_W];
endmodule

@@ rtl/drs_div.sv @@
// Pipelined rounded divide of the three components by the norm: one quotient bit per stage.
module drs_div import drs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [2:0][GS_W-1:0] gs_i,
  input  logic [N_W-1:0]       n_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic [2:0][Q_W-1:0]  q_o,
  output logic [2:0]           neg_o
);
  logic                 vld [Q_W+1];
  side_t                sd  [Q_W+1];
  logic [N_W-1:0]       den [Q_W+1];
  logic [2:0][DV_W-1:0] rem [Q_W+1];
  logic [2:0][Q_W-1:0]  quo [Q_W+1];
  logic [2:0]           neg [Q_W+1];

  always_comb begin
    logic [GS_W-1:0] a;
    for (int k = 0; k < 3; k++) begin
      a = gs_i[k][GS_W-1] ? (~gs_i[k] + GS_W'(1)) : gs_i[k];
      rem[0][k] = DV_W'({a[UNIT_W-1:0], UNIT_W'(0)}) + DV_W'(n_i >> 1);
      neg[0][k] = gs_i[k][GS_W-1];
    end
  end

  assign vld[0] = valid_i;
  assign sd[0]  = side_i;
  assign den[0] = n_i;
  assign quo[0] = '0;

  for (genvar s = 0; s < Q_W; s++) begin : g_bit
    localparam int BIT = Q_W - 1 - s;
    logic [DV_W:0]        dsh;
    logic [2:0][DV_W-1:0] rem_d;
    logic [2:0][Q_W-1:0]  quo_d;

    assign dsh = (DV_W + 1)'(den[s]) << BIT;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        quo_d[k] = quo[s][k];
        rem_d[k] = rem[s][k];
        if ({1'b0, rem[s][k]} >= dsh) begin
          rem_d[k] = rem[s][k] - dsh[DV_W-1:0];
          quo_d[k][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd[s+1]  <= sd[s];
        den[s+1] <= den[s];
        rem[s+1] <= rem_d;
        quo[s+1] <= quo_d;
        neg[s+1] <= neg[s];
      end
    end
  end

  assign valid_o = vld[Q_W];
  assign side_o  = sd[Q_W];
  assign q_o     = quo[Q_W];
  assign neg_o   = neg[Q_W];
endmodule

@@ rtl/dipole_rotational_diffusion_step.sv @@
// Path: an accepted input word passes rotate, normalize, square root, divide, then the product and result registers.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// The depth is set by the root and divide chains, one result bit per stage each.
// Reset clears step_gain, planar_mode and every stage valid bit; no clearing pass.
// Config registers: step_gain at byte 0, planar_mode at byte 4.
`include "dipole_rotational_diffusion_step_macros.svh"
module dipole_rotational_diffusion_step import drs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  drs_in_if.sink            dip_i,
  drs_out_if.source         dip_o
);
  cfg_t                  cfg_q;
  logic                  en;
  logic                  cfg_wr;
  logic [IDX_W-1:0]      cfg_idx;
  side_t                 in_side;
  logic [2:0][NOISE_W-1:0] in_noise;

  logic                  rot_vld;
  side_t                 rot_side;
  logic [2:0][G_W-1:0]   rot_g;
  logic                  nrm_vld;
  side_t                 nrm_side;
  logic [2:0][GS_W-1:0]  nrm_gs;
  logic [SQ_W-1:0]       nrm_sum;
  logic                  sqr_vld;
  side_t                 sqr_side;
  logic [2:0][GS_W-1:0]  sqr_gs;
  logic [N_W-1:0]        sqr_root;
  logic                  div_vld;
  side_t                 div_side;
  logic [2:0][Q_W-1:0]   div_q;
  logic [2:0]            div_neg;

  logic                  mul_vld_q;
  side_t                 mul_side_q;
  logic [2:0][UP_W-1:0]  prod_d, prod_q;
  logic [2:0][DIP_W-1:0] res_d, res_q;
  logic                  out_vld_q;
  logic                  degen_q;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN:   cfg_q.gain   <= pwdata[GAIN_W-1:0];
        REG_PLANAR: cfg_q.planar <= pwdata[0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN:   prdata = APB_W'(cfg_q.gain);
      REG_PLANAR: prdata = APB_W'(cfg_q.planar);
      default:    prdata = '0;
    endcase
  end

  assign en          = !out_vld_q || dip_o.ready;
  assign dip_i.ready = en;

  always_comb begin
    in_side.mu     = {dip_i.dip_z, dip_i.dip_y, dip_i.dip_x};
    in_side.mag    = dip_i.dip_magnitude;
    in_side.active = dip_i.in_group && (dip_i.dip_magnitude != '0);
    in_side.degen  = 1'b0;
    in_noise       = {dip_i.noise_z, dip_i.noise_y, dip_i.noise_x};
  end

  drs_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (dip_i.valid),
    .side_i  (in_side),
    .noise_i (in_noise),
    .valid_o (rot_vld),
    .side_o  (rot_side),
    .g_o     (rot_g)
  );

  drs_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_vld),
    .side_i  (rot_side),
    .g_i     (rot_g),
    .valid_o (nrm_vld),
    .side_o  (nrm_side),
    .gs_o    (nrm_gs),
    .sum_o   (nrm_sum)
  );

  drs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nrm_vld),
    .side_i  (nrm_side),
    .gs_i    (nrm_gs),
    .sum_i   (nrm_sum),
    .valid_o (sqr_vld),
    .side_o  (sqr_side),
    .gs_o    (sqr_gs),
    .root_o  (sqr_root)
  );

  drs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqr_vld),
    .side_i  (sqr_side),
    .gs_i    (sqr_gs),
    .n_i     (sqr_root),
    .valid_o (div_vld),
    .side_o  (div_side),
    .q_o     (div_q),
    .neg_o   (div_neg)
  );

  always_comb begin
    logic [GS_W-1:0] u;
    for (int k = 0; k < 3; k++) begin
      u = GS_W'(div_q[k]);
      if (div_neg[k]) begin
        u = ~u + GS_W'(1);
      end
      prod_d[k] = $signed(u) * $signed({1'b0, div_side.mag});
    end
  end

  always_comb begin
    logic [UP_W-1:0] r;
    logic [RS_W-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      r  = prod_q[k] + (UP_W'(1) << (UNIT_W - 1));
      sh = r[UNIT_W +: RS_W];
      if (sh[RS_W-1:DIP_W-1] == '0 || sh[RS_W-1:DIP_W-1] == '1) begin
        res_d[k] = sh[DIP_W-1:0];
      end else begin
        res_d[k] = {sh[RS_W-1], {(DIP_W - 1){~sh[RS_W-1]}}};
      end
      if (!mul_side_q.active || mul_side_q.degen) begin
        res_d[k] = mul_side_q.mu[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= div_vld;
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_side_q <= div_side;
      prod_q     <= prod_d;
      res_q      <= res_d;
      degen_q    <= mul_side_q.degen;
    end
  end

  assign dip_o.valid      = out_vld_q;
  assign dip_o.new_x      = res_q[0];
  assign dip_o.new_y      = res_q[1];
  assign dip_o.new_z      = res_q[2];
  assign dip_o.degenerate = degen_q;

  `DRS_ASSERT_IMP(a_norm_nonzero, nrm_vld && nrm_side.active && !nrm_side.degen, nrm_sum != '0)
  `DRS_ASSERT_NXT(a_gain_write, cfg_wr && cfg_idx == REG_GAIN, cfg_q.gain == $past(pwdata[GAIN_W-1:0]))
  `DRS_ASSERT_NXT(a_stall_hold, !en, div_vld == $past(div_vld) && div_q == $past(div_q))
  `DRS_ASSERT_IMP(a_degen_active, mul_vld_q && mul_side_q.degen, mul_side_q.active)
endmodule
